### hdl/npst_pkg.sv
package npst_pkg;

    localparam int MAX_BLOCK_COUNT = 16384;
    localparam int MAX_PAGE_COUNT  = 1024;

    localparam int BLK_W      = 14;
    localparam int PAGE_W     = 10;
    localparam int NP_W       = 11;
    localparam int EC_W       = 32;
    localparam int CMD_W      = 2;
    localparam int STATUS_W   = 2;
    localparam int BCOUNT_W   = 15;
    localparam int PCOUNT_W   = 11;
    localparam int CFG_DATA_W = 15;
    localparam int CFG_IDX_W  = 1;
    localparam int ENTRY_W    = NP_W + EC_W;

    localparam logic [CMD_W-1:0] CMD_PROGRAM = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_ERASE   = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK          = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_WRONG_ADDR  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_OVER_PROG   = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY_PAGE  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT     = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PAGES_PER_BLOCK = 1'd1;

    localparam logic [BCOUNT_W-1:0] BLOCK_COUNT_RESET     = 15'd16384;
    localparam logic [PCOUNT_W-1:0] PAGES_PER_BLOCK_RESET = 11'd256;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [BLK_W-1:0]  block_number;
        logic [PAGE_W-1:0] page_number;
    } t_in_item;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [NP_W-1:0]     next_page;
        logic [EC_W-1:0]     erase_total;
    } t_out_item;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_EXEC
    } t_state;

    typedef struct packed {
        logic clr_en;
        logic load_item;
        logic exec_go;
    } t_ctrl_cmd;

    typedef struct packed {
        logic clr_last;
        logic out_free;
    } t_dp_status;

endpackage

### hdl/nand_page_state_tracker_core.sv
// Bookkeeping core of a NAND flash model. Each item is a program, read or
// erase command for one block and page; the core checks the address against
// the block_count and pages_per_block registers and answers with one result
// item: a status (ok, wrong address, over program, empty page), the block's
// next programmable page and its 32-bit erase count after the command.
// Per-block state lives in one table of 16384 entries with a read and a
// write port; after reset the core sweeps it to zero, one entry a cycle,
// and holds o_in_stall high until the sweep is done (configuration writes
// are taken meanwhile). An item is captured at acceptance, its entry read
// in ST_READ, then updated and written back in ST_EXEC, which waits for a
// free output register and registers the result there, so o_out_valid
// rises once the write-back is done; the table's read-modify-write keeps
// out a new item until then. A finished result sits in an output register
// while the next item is accepted; o_in_stall also stays high when a second
// result is ready and the first has not yet been taken.
module nand_page_state_tracker_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  npst_pkg::t_in_item                i_in_item,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output npst_pkg::t_out_item               o_out_item,
    input  logic                              i_cfg_we,
    input  logic [npst_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [npst_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    // command from the sequencer, status back from the datapath
    npst_pkg::t_ctrl_cmd  ctrl_cmd;
    npst_pkg::t_dp_status dp_status;

    npst_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (dp_status),
        .o_cmd      (ctrl_cmd),
        .o_in_stall (o_in_stall)
    );

    // table, config registers, result logic and output register
    npst_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (ctrl_cmd),
        .o_status    (dp_status),
        .i_in_item   (i_in_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    // right after reset, as the table sweep begins, no item may enter
    a_stall_after_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> o_in_stall)
        else $error("item accepted during table clear");

endmodule

### hdl/npst_ctrl.sv
module npst_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  npst_pkg::t_dp_status  i_status,
    output npst_pkg::t_ctrl_cmd   o_cmd,
    output logic                  o_in_stall
);

    npst_pkg::t_state r_state;
    npst_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= npst_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state         = r_state;
        o_cmd           = '0;
        o_in_stall      = 1'b1;
        case (r_state)
            npst_pkg::ST_CLEAR: begin
                o_cmd.clr_en = 1'b1;
                if (i_status.clr_last) begin
                    n_state = npst_pkg::ST_IDLE;
                end
            end
            npst_pkg::ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_state         = npst_pkg::ST_READ;
                end
            end
            npst_pkg::ST_READ: begin
                n_state = npst_pkg::ST_EXEC;
            end
            npst_pkg::ST_EXEC: begin
                if (i_status.out_free) begin
                    o_cmd.exec_go = 1'b1;
                    n_state       = npst_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = npst_pkg::ST_IDLE;
            end
        endcase
    end

    a_exec_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == npst_pkg::ST_EXEC && !i_status.out_free) |=> (r_state == npst_pkg::ST_EXEC))
        else $error("command left execute without an output slot");

endmodule

### hdl/npst_datapath.sv
module npst_datapath (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  npst_pkg::t_ctrl_cmd                   i_cmd,
    output npst_pkg::t_dp_status                  o_status,
    input  npst_pkg::t_in_item                    i_in_item,
    input  logic                                  i_cfg_we,
    input  logic [npst_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [npst_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output npst_pkg::t_out_item                   o_out_item
);

    // pointer in the low bits, erase count above it
    logic [npst_pkg::ENTRY_W-1:0] r_mem [npst_pkg::MAX_BLOCK_COUNT];
    logic [npst_pkg::ENTRY_W-1:0] r_rd_data;

    logic [npst_pkg::BCOUNT_W-1:0] r_block_count;
    logic [npst_pkg::PCOUNT_W-1:0] r_pages_per_block;
    logic [npst_pkg::BLK_W-1:0]    r_clr_addr;
    npst_pkg::t_in_item            r_item;
    logic                          r_out_valid;
    npst_pkg::t_out_item           r_out;
    logic                          n_out_valid;

    logic                          blk_ok;
    logic                          page_ok;
    logic [npst_pkg::NP_W-1:0]     np_cur;
    logic [npst_pkg::EC_W-1:0]     ec_cur;
    logic [npst_pkg::NP_W-1:0]     page_ext;
    logic                          below_ptr;
    npst_pkg::t_out_item           result;
    logic                          upd_en;
    logic [npst_pkg::ENTRY_W-1:0]  upd_data;
    logic                          mem_we;
    logic [npst_pkg::BLK_W-1:0]    mem_waddr;
    logic [npst_pkg::ENTRY_W-1:0]  mem_wdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_count     <= npst_pkg::BLOCK_COUNT_RESET;
            r_pages_per_block <= npst_pkg::PAGES_PER_BLOCK_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                npst_pkg::REG_BLOCK_COUNT:
                    r_block_count <= i_cfg_data[npst_pkg::BCOUNT_W-1:0];
                npst_pkg::REG_PAGES_PER_BLOCK:
                    r_pages_per_block <= i_cfg_data[npst_pkg::PCOUNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr_en) begin
            r_clr_addr <= r_clr_addr + npst_pkg::BLK_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_item <= i_in_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= r_mem[r_item.block_number];
    end

    always_comb begin
        np_cur    = r_rd_data[npst_pkg::NP_W-1:0];
        ec_cur    = r_rd_data[npst_pkg::ENTRY_W-1:npst_pkg::NP_W];
        page_ext  = {1'b0, r_item.page_number};
        blk_ok    = {1'b0, r_item.block_number} < r_block_count;
        page_ok   = page_ext < r_pages_per_block;
        below_ptr = page_ext < np_cur;

        result.status      = npst_pkg::STATUS_WRONG_ADDR;
        result.next_page   = '0;
        result.erase_total = '0;
        upd_en             = 1'b0;
        upd_data           = r_rd_data;

        case (r_item.command)
            npst_pkg::CMD_PROGRAM: begin
                if (blk_ok && page_ok) begin
                    result.erase_total = ec_cur;
                    if (below_ptr) begin
                        result.status    = npst_pkg::STATUS_OVER_PROG;
                        result.next_page = np_cur;
                    end else begin
                        result.status    = npst_pkg::STATUS_OK;
                        result.next_page = page_ext + npst_pkg::NP_W'(1);
                        upd_en           = 1'b1;
                        upd_data         = {ec_cur, result.next_page};
                    end
                end
            end
            npst_pkg::CMD_READ: begin
                if (blk_ok && page_ok) begin
                    result.status      = below_ptr ? npst_pkg::STATUS_OK
                                                   : npst_pkg::STATUS_EMPTY_PAGE;
                    result.next_page   = np_cur;
                    result.erase_total = ec_cur;
                end
            end
            npst_pkg::CMD_ERASE: begin
                if (blk_ok) begin
                    result.status      = npst_pkg::STATUS_OK;
                    result.erase_total = ec_cur + npst_pkg::EC_W'(1);
                    upd_en             = 1'b1;
                    upd_data           = {result.erase_total, npst_pkg::NP_W'(0)};
                end
            end
            default: begin
            end
        endcase

        mem_we    = i_cmd.clr_en || (i_cmd.exec_go && upd_en);
        mem_waddr = i_cmd.clr_en ? r_clr_addr : r_item.block_number;
        mem_wdata = i_cmd.clr_en ? '0 : upd_data;
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (i_cmd.exec_go) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec_go) begin
            r_out <= result;
        end
    end

    assign o_status.clr_last = &r_clr_addr;
    assign o_status.out_free = !r_out_valid || !i_out_stall;
    assign o_out_valid       = r_out_valid;
    assign o_out_item        = r_out;

    a_no_write_on_bad_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec_go && result.status == npst_pkg::STATUS_WRONG_ADDR) |-> !mem_we)
        else $error("table written for a wrong address");

    a_erase_clears_ptr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec_go && r_item.command == npst_pkg::CMD_ERASE && blk_ok)
        |=> (r_out.next_page == '0 && r_out.status == npst_pkg::STATUS_OK))
        else $error("erase result does not show a cleared pointer");

    a_exec_only_with_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.exec_go |-> (!r_out_valid || !i_out_stall))
        else $error("result overwrote an item not yet taken");

endmodule
